>>> rtl/aes_cbc_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 CBC/ECB package
// Shared types, constants and round functions for the block cipher engine.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_cbc_pkg;

    localparam int unsigned BlockBits = 128;
    localparam int unsigned HalfBits  = 64;
    localparam int unsigned CntBits   = 5;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned RkDepth   = 22;
    localparam int unsigned RkAddrBits = 5;
    localparam int unsigned CfgIdxBits = 3;

    localparam logic [CfgIdxBits-1:0] RegDirection = 3'd0;
    localparam logic [CfgIdxBits-1:0] RegChainMode = 3'd1;
    localparam logic [CfgIdxBits-1:0] RegKeyHigh   = 3'd2;
    localparam logic [CfgIdxBits-1:0] RegKeyLow    = 3'd3;
    localparam logic [CfgIdxBits-1:0] RegIvHigh    = 3'd4;
    localparam logic [CfgIdxBits-1:0] RegIvLow     = 3'd5;

    localparam logic [CntBits-1:0] FullCount = 5'd16;

    typedef enum logic [2:0] {
        ST_KEYEXP,
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [HalfBits-1:0] out_high;
        logic [HalfBits-1:0] out_low;
        logic [CntBits-1:0]  valid_bytes;
        logic                last_out;
        logic                pad_error;
    } t_result;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (sbox(8'(i)) == a) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Byte n of a block, byte 0 in the top bits.
    function automatic logic [7:0] bget(input logic [BlockBits-1:0] s, input int n);
        return s[BlockBits-1-8*n -: 8];
    endfunction

    // One forward round: SubBytes, ShiftRows and (unless final) MixColumns.
    function automatic logic [BlockBits-1:0] enc_round(input logic [BlockBits-1:0] s,
                                                       input logic fin);
        logic [7:0] t [16];
        logic [BlockBits-1:0] o;
        logic [7:0] a0, a1, a2, a3;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = sbox(bget(s, 4*((c+r)%4)+r));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (fin) begin
                o[BlockBits-1-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[BlockBits-1-32*c -: 32] = {
                    xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                    xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return o;
    endfunction

    // Inverse ShiftRows and SubBytes.
    function automatic logic [BlockBits-1:0] dec_sub(input logic [BlockBits-1:0] s);
        logic [7:0] t [16];
        logic [BlockBits-1:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*((c+r)%4)+r] = inv_sbox(bget(s, 4*c+r));
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[BlockBits-1-8*i -: 8] = t[i];
        end
        return o;
    endfunction

    function automatic logic [BlockBits-1:0] inv_mix(input logic [BlockBits-1:0] s);
        logic [BlockBits-1:0] o;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = bget(s, 4*c+r);
                x2[r] = xtime(a[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
            end
            // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
            for (int r = 0; r < 4; r++) begin
                o[BlockBits-1-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

>>> rtl/aes_cbc_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface aes_cbc_stream_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/aes_cbc_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Single-entry output holding register between the cipher core and the sink.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_cbc_out_reg (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_load,
    input  wire aes_cbc_pkg::t_result     i_res,
    output logic                          o_busy,
    aes_cbc_stream_if.source              o_out
);
    logic                 r_valid;
    aes_cbc_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_busy      = r_valid && !o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_res;
endmodule
`default_nettype wire

>>> rtl/aes128_cbc_ecb_pkcs7.sv
// ----------------------------------------------------------------------------
// AES-128 ECB/CBC engine with PKCS#7 padding
// Encrypts or decrypts 128-bit blocks with one shared round unit.
// ----------------------------------------------------------------------------
// Flow: the input transaction issues the key read for the whitening step, then
// come whitening, ten rounds and the output load, which waits while the output
// register is full. A new transaction is taken only once the engine is back in
// idle; a full final encrypt block adds a pad block, which goes from the output
// load straight to whitening. After reset or a key write the round keys are
// rebuilt, during which no input transaction is taken. Reset clears control
// and chain state.
`default_nettype none
module aes128_cbc_ecb_pkcs7 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    aes_cbc_stream_if.sink   i_in,
    aes_cbc_stream_if.source o_out
);
    localparam int unsigned BB = aes_cbc_pkg::BlockBits;
    localparam int unsigned HB = aes_cbc_pkg::HalfBits;
    localparam int unsigned AB = aes_cbc_pkg::RkAddrBits;

    // Input payload: data_high, data_low, byte_count, last_block.
    logic [HB-1:0] w_in_high, w_in_low;
    logic [4:0]    w_in_cnt;
    logic          w_in_last;
    assign {w_in_high, w_in_low, w_in_cnt, w_in_last} = i_in.data;

    // Configuration registers.
    logic          r_dir, r_cbc;
    logic [HB-1:0] r_key_hi, r_key_lo;
    logic [BB-1:0] r_chain;

    // Round key memory: 11 round keys as 22 halves, written by the expander.
    logic [HB-1:0] r_rk_mem [aes_cbc_pkg::RkDepth];
    logic [BB-1:0] r_rk_rd;

    aes_cbc_pkg::t_state r_state, n_state;
    logic [3:0]    r_rnd;        // round counter
    logic [5:0]    r_kx;         // key expansion word index 4..43
    logic [BB-1:0] r_kw;         // last four expansion words
    logic [BB-1:0] r_s;          // cipher state
    logic [BB-1:0] r_ct;         // ciphertext copy for the decrypt chain
    logic          r_last, r_pad_next, r_dec;
    logic          w_busy, w_load, w_accept;
    aes_cbc_pkg::t_result w_res;

    // The memory is 64 bits wide; a round key is read as one two-entry row,
    // modelled as two reads of adjacent halves at an address the round sets.
    logic [3:0]    w_rd_round;
    logic [AB-1:0] w_rd_a;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == aes_cbc_pkg::ST_IDLE) && !i_cfg_we;

    // The expander seeds its word window from the key at the first step.
    logic [BB-1:0] w_kw_win;
    assign w_kw_win = (r_kx == 6'd4) ? {r_key_hi, r_key_lo} : r_kw;

    // Key expansion: one 32-bit word per cycle, the word pair written when odd.
    logic [31:0] w_prev, w_t, w_new;
    always_comb begin
        w_prev = w_kw_win[31:0];
        w_t    = w_prev;
        if (r_kx[1:0] == 2'd0) begin
            w_t = {aes_cbc_pkg::sbox(w_prev[23:16]) ^ aes_cbc_pkg::rcon(r_kx[5:2]),
                   aes_cbc_pkg::sbox(w_prev[15:8]),
                   aes_cbc_pkg::sbox(w_prev[7:0]),
                   aes_cbc_pkg::sbox(w_prev[31:24])};
        end
        w_new = w_kw_win[BB-1 -: 32] ^ w_t;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == aes_cbc_pkg::ST_KEYEXP) begin
            r_kw <= {w_kw_win[BB-33:0], w_new};
            if (r_kx[0]) begin
                r_rk_mem[AB'(r_kx[5:1])] <= {w_kw_win[31:0], w_new};
            end
        end else if (i_cfg_we && (i_cfg_idx == aes_cbc_pkg::RegKeyHigh ||
                                  i_cfg_idx == aes_cbc_pkg::RegKeyLow)) begin
            r_kw <= '0;
        end else if (r_state != aes_cbc_pkg::ST_KEYEXP && r_kx == 6'd0) begin
            r_kw <= '0;
        end
        if (r_state == aes_cbc_pkg::ST_KEYEXP && r_kx == 6'd4) begin
            r_rk_mem[0] <= r_key_hi;
            r_rk_mem[1] <= r_key_lo;
        end
    end

    // Round key read, registered. Each cycle fetches the key that the next
    // cycle consumes; the read in the last round and in the output cycle
    // fetches round key 0 for a following pad block.
    always_comb begin
        case (r_state)
            aes_cbc_pkg::ST_IDLE: w_rd_round = r_dir ? 4'd10 : 4'd0;
            aes_cbc_pkg::ST_LOAD: w_rd_round = r_dec ? 4'd9 : 4'd1;
            aes_cbc_pkg::ST_ROUND: begin
                if (r_rnd == 4'd9) begin
                    w_rd_round = 4'd0;
                end else begin
                    w_rd_round = r_dec ? 4'd8 - r_rnd : r_rnd + 4'd2;
                end
            end
            default: w_rd_round = 4'd0;
        endcase
        w_rd_a = AB'({w_rd_round, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        r_rk_rd <= {r_rk_mem[w_rd_a], r_rk_mem[w_rd_a + AB'(1)]};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            aes_cbc_pkg::ST_KEYEXP: if (r_kx == 6'd43) n_state = aes_cbc_pkg::ST_IDLE;
            aes_cbc_pkg::ST_IDLE:   if (w_accept) n_state = aes_cbc_pkg::ST_LOAD;
            aes_cbc_pkg::ST_LOAD:   n_state = aes_cbc_pkg::ST_ROUND;
            aes_cbc_pkg::ST_ROUND:  if (r_rnd == 4'd9) n_state = aes_cbc_pkg::ST_OUT;
            aes_cbc_pkg::ST_OUT: begin
                if (!w_busy) begin
                    n_state = r_pad_next ? aes_cbc_pkg::ST_LOAD : aes_cbc_pkg::ST_IDLE;
                end
            end
            default: n_state = aes_cbc_pkg::ST_IDLE;
        endcase
        if (i_cfg_we && (i_cfg_idx == aes_cbc_pkg::RegKeyHigh ||
                         i_cfg_idx == aes_cbc_pkg::RegKeyLow)) begin
            n_state = aes_cbc_pkg::ST_KEYEXP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_cbc_pkg::ST_KEYEXP;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= 1'b0;
            r_cbc    <= 1'b1;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_kx     <= 6'd4;
        end else begin
            if (r_state == aes_cbc_pkg::ST_KEYEXP) begin
                r_kx <= r_kx + 6'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aes_cbc_pkg::RegDirection: r_dir <= i_cfg_data[0];
                    aes_cbc_pkg::RegChainMode: r_cbc <= i_cfg_data[0];
                    aes_cbc_pkg::RegKeyHigh: begin
                        r_key_hi <= i_cfg_data;
                        r_kx     <= 6'd4;
                    end
                    aes_cbc_pkg::RegKeyLow: begin
                        r_key_lo <= i_cfg_data;
                        r_kx     <= 6'd4;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Cipher datapath. Input padding happens at the transaction; a full pad block is built at the output load.
    logic [BB-1:0] w_blk, w_pt, w_dec_out;
    logic [4:0]    w_cnt_sat;
    logic [7:0]    w_pad_byte;
    always_comb begin
        w_cnt_sat  = (w_in_cnt > aes_cbc_pkg::FullCount) ? aes_cbc_pkg::FullCount : w_in_cnt;
        w_pad_byte = 8'(aes_cbc_pkg::FullCount - w_cnt_sat);
        w_blk = {w_in_high, w_in_low};
        if (!r_dir && w_in_last) begin
            for (int i = 0; i < 16; i++) begin
                if (5'(i) >= w_cnt_sat) begin
                    w_blk[BB-1-8*i -: 8] = w_pad_byte;
                end
            end
        end
        w_pt = w_blk;
        if (!r_dir && r_cbc) begin
            w_pt = w_blk ^ r_chain;
        end
        w_dec_out = r_cbc ? (r_s ^ r_chain) : r_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_next <= 1'b0;
            r_rnd      <= 4'd0;
            r_chain    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == aes_cbc_pkg::RegIvHigh) begin
                r_chain[BB-1 -: HB] <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == aes_cbc_pkg::RegIvLow) begin
                r_chain[HB-1:0] <= i_cfg_data;
            end
            case (r_state)
                aes_cbc_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_s        <= w_pt;
                        r_ct       <= w_blk;
                        r_dec      <= r_dir;
                        r_last     <= w_in_last;
                        r_pad_next <= !r_dir && w_in_last && (w_cnt_sat == aes_cbc_pkg::FullCount);
                    end
                end
                aes_cbc_pkg::ST_LOAD: begin
                    // Whitening with round key 0 (or 10 on decrypt).
                    r_s   <= r_s ^ r_rk_rd;
                    r_rnd <= 4'd0;
                end
                aes_cbc_pkg::ST_ROUND: begin
                    if (r_dec) begin
                        r_s <= (r_rnd == 4'd9) ?
                               (aes_cbc_pkg::dec_sub(r_s) ^ r_rk_rd) :
                               aes_cbc_pkg::inv_mix(aes_cbc_pkg::dec_sub(r_s) ^ r_rk_rd);
                    end else begin
                        r_s <= aes_cbc_pkg::enc_round(r_s, r_rnd == 4'd9) ^ r_rk_rd;
                    end
                    r_rnd <= r_rnd + 4'd1;
                end
                aes_cbc_pkg::ST_OUT: begin
                    if (!w_busy) begin
                        if (r_cbc) begin
                            r_chain <= r_dec ? r_ct : r_s;
                        end
                        if (r_pad_next) begin
                            r_pad_next <= 1'b0;
                            r_s        <= r_cbc ? ({16{8'h10}} ^ r_s) : {16{8'h10}};
                            r_last     <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result assembly.
    logic [7:0] w_pb;
    always_comb begin
        w_res.out_high    = r_dec ? w_dec_out[BB-1 -: HB] : r_s[BB-1 -: HB];
        w_res.out_low     = r_dec ? w_dec_out[HB-1:0] : r_s[HB-1:0];
        w_pb              = w_dec_out[7:0];
        w_res.last_out    = r_last && !r_pad_next;
        w_res.pad_error   = 1'b0;
        w_res.valid_bytes = aes_cbc_pkg::FullCount;
        if (r_dec && r_last) begin
            if (w_pb == 8'd0 || w_pb > 8'd16) begin
                w_res.pad_error   = 1'b1;
                w_res.valid_bytes = 5'd0;
            end else begin
                w_res.valid_bytes = 5'(8'd16 - w_pb);
            end
        end
    end

    assign w_load = (r_state == aes_cbc_pkg::ST_OUT) && !w_busy;

    aes_cbc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .o_busy  (w_busy),
        .o_out   (o_out)
    );

    // No input transaction is taken while a block is in flight.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != aes_cbc_pkg::ST_IDLE) |-> !i_in.ready)
        else $error("input taken while busy");

    // The round counter never runs past the last round.
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_cbc_pkg::ST_ROUND) |-> (r_rnd <= 4'd9))
        else $error("round counter overrun");

    // A result is loaded only when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !(o_out.valid && !o_out.ready))
        else $error("result overwritten");
endmodule
`default_nettype wire
